@@ sv/u7e1_pkg.sv @@
// shared types, constants and ring helpers for the 7e1 serial receiver
// no dependencies; used by the result and configuration interfaces, the ring storage and the top level
package u7e1_pkg;

  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned TICKS_W    = 9;
  localparam int unsigned BITIDX_W   = 4;
  localparam int unsigned ONES_W     = 3;
  localparam int unsigned AVAIL_W    = 5;

  // bit positions within a frame, counted from the start bit
  localparam logic [BITIDX_W-1:0] FIRST_DATA_BIT = 4'd1;
  localparam logic [BITIDX_W-1:0] LAST_DATA_BIT  = 4'd7;
  localparam logic [BITIDX_W-1:0] PARITY_BIT     = 4'd8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd52;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef logic [RING_AW-1:0] ring_idx_t;

  typedef struct packed {
    logic                 read_valid;
    logic [AVAIL_W-1:0]   bytes_available;
    logic                 byte_stored;
    logic                 overflow;
    logic                 parity_error;
    logic                 stop_error;
  } rsp_flags_t;

  function automatic ring_idx_t ring_next(input ring_idx_t idx);
    ring_idx_t nxt;
    if (idx == RING_AW'(RING_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + ring_idx_t'(1);
    end
    return nxt;
  endfunction

  function automatic ring_idx_t ring_count(input ring_idx_t wr, input ring_idx_t rd);
    logic [RING_AW:0] diff;
    if (wr >= rd) begin
      diff = {1'b0, wr} - {1'b0, rd};
    end else begin
      diff = {1'b0, wr} + (RING_AW + 1)'(RING_DEPTH) - {1'b0, rd};
    end
    return diff[RING_AW-1:0];
  endfunction

endpackage

@@ sv/u7e1_req_if.sv @@
// request channel of the 7e1 receiver: line tick or byte read
// no dependencies
interface u7e1_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic rx_level;

  modport source (output valid, output req_type, output rx_level, input ready);
  modport sink   (input valid, input req_type, input rx_level, output ready);
endinterface

@@ sv/u7e1_rsp_if.sv @@
// result channel of the 7e1 receiver, one transaction per request
// depends on u7e1_pkg for field widths
interface u7e1_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          read_valid;
  logic [u7e1_pkg::CHAR_W-1:0]   read_byte;
  logic [u7e1_pkg::AVAIL_W-1:0]  bytes_available;
  logic                          byte_stored;
  logic                          overflow;
  logic                          parity_error;
  logic                          stop_error;

  modport source (output valid, output read_valid, output read_byte,
                  output bytes_available, output byte_stored, output overflow,
                  output parity_error, output stop_error, input ready);
  modport sink   (input valid, input read_valid, input read_byte,
                  input bytes_available, input byte_stored, input overflow,
                  input parity_error, input stop_error, output ready);
endinterface

@@ sv/u7e1_cfg_if.sv @@
// configuration write channel: bit period in ticks
// depends on u7e1_pkg for the data width
interface u7e1_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [u7e1_pkg::PERIOD_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/u7e1_ring.sv @@
// receive ring storage: one write port, one read port with registered data
// depends on u7e1_pkg
module u7e1_ring (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  u7e1_pkg::ring_idx_t           wr_addr_i,
  input  logic [u7e1_pkg::CHAR_W-1:0]   wr_data_i,
  input  logic                          rd_en_i,
  input  u7e1_pkg::ring_idx_t           rd_addr_i,
  output logic [u7e1_pkg::CHAR_W-1:0]   rd_data_o
);

  logic [u7e1_pkg::CHAR_W-1:0] mem [u7e1_pkg::RING_DEPTH];
  logic [u7e1_pkg::CHAR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/uart_rx_7e1_fifo_unit.sv @@
// top level of the 7e1 serial receiver with a 32-entry receive ring
// depends on u7e1_pkg, u7e1_req_if, u7e1_rsp_if, u7e1_cfg_if and u7e1_ring
//
// usage:
//   req_i carries one transaction per timer tick (req_type 0, rx_level is the
//   sampled line) or per byte read (req_type 1). every request produces
//   exactly one transaction on rsp_o, in order.
//   a falling edge while idle starts a frame; bits are sampled (period/2)*3
//   ticks after the edge and then every period ticks. the character is pushed
//   at the last data bit (or dropped with overflow when the ring holds 31),
//   parity and stop errors are reported on the stop bit tick.
//   cfg_i writes the bit period; it is always ready and must only be written
//   while no request is in flight.
// response: registered; it appears in the cycle after the request is accepted.
// throughput: one request per cycle; req_i.ready is high whenever the output
//   register is empty or being drained in the same cycle, so a stalled
//   receiver holds the response and backpressures requests one for one.
// reset: line taken as idle, no frame in progress, ring empty, period 52.
//   ring contents are not cleared; only written entries are ever read.
module uart_rx_7e1_fifo_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  u7e1_req_if.sink    req_i,
  u7e1_rsp_if.source  rsp_o,
  u7e1_cfg_if.sink    cfg_i
);

  logic [u7e1_pkg::PERIOD_W-1:0] period_q;

  logic                            line_prev_q, line_prev_d;
  logic                            in_frame_q, in_frame_d;
  logic [u7e1_pkg::TICKS_W-1:0]    ticks_q, ticks_d;
  logic [u7e1_pkg::BITIDX_W-1:0]   bit_idx_q, bit_idx_d;
  logic [u7e1_pkg::CHAR_W-1:0]     shift_q, shift_d;
  logic [u7e1_pkg::ONES_W-1:0]     ones_q, ones_d;
  logic                            parity_q, parity_d;
  u7e1_pkg::ring_idx_t             wr_idx_q, wr_idx_d;
  u7e1_pkg::ring_idx_t             rd_idx_q, rd_idx_d;

  logic                            rsp_valid_q;
  u7e1_pkg::rsp_flags_t            flags_q, flags_d;

  logic                            accept;
  logic                            is_read;
  logic                            wr_en;
  logic [u7e1_pkg::BITIDX_W-1:0]   bit_nx;
  logic [u7e1_pkg::CHAR_W-1:0]     rd_data;
  logic [u7e1_pkg::TICKS_W-1:0]    first_wait;
  logic [u7e1_pkg::PERIOD_W-2:0]   half_period;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_read     = (req_i.req_type == u7e1_pkg::REQ_READ);
  assign cfg_i.ready = 1'b1;

  // (period/2)*3 as half + 2*half
  assign half_period = period_q[u7e1_pkg::PERIOD_W-1:1];
  assign first_wait  = u7e1_pkg::TICKS_W'(half_period)
                     + u7e1_pkg::TICKS_W'({half_period, 1'b0});

  always_comb begin
    line_prev_d = line_prev_q;
    in_frame_d  = in_frame_q;
    ticks_d     = ticks_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    ones_d      = ones_q;
    parity_d    = parity_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    wr_en       = 1'b0;
    bit_nx      = bit_idx_q + u7e1_pkg::BITIDX_W'(1);
    flags_d     = '0;

    if (accept) begin
      if (is_read) begin
        if (wr_idx_q != rd_idx_q) begin
          flags_d.read_valid = 1'b1;
          rd_idx_d           = u7e1_pkg::ring_next(rd_idx_q);
        end
      end else if (!in_frame_q) begin
        if (!req_i.rx_level && line_prev_q) begin
          in_frame_d = 1'b1;
          ticks_d    = first_wait;
          bit_idx_d  = '0;
          shift_d    = '0;
          ones_d     = '0;
        end
        line_prev_d = req_i.rx_level;
      end else begin
        if (ticks_q <= u7e1_pkg::TICKS_W'(1)) begin
          ticks_d   = u7e1_pkg::TICKS_W'(period_q);
          bit_idx_d = bit_nx;
          if (bit_nx >= u7e1_pkg::FIRST_DATA_BIT && bit_nx <= u7e1_pkg::LAST_DATA_BIT) begin
            shift_d = shift_q | (u7e1_pkg::CHAR_W'(req_i.rx_level)
                      << (bit_nx - u7e1_pkg::FIRST_DATA_BIT));
            ones_d  = ones_q + u7e1_pkg::ONES_W'(req_i.rx_level);
            if (bit_nx == u7e1_pkg::LAST_DATA_BIT) begin
              if (u7e1_pkg::ring_next(wr_idx_q) != rd_idx_q) begin
                wr_en               = 1'b1;
                wr_idx_d            = u7e1_pkg::ring_next(wr_idx_q);
                flags_d.byte_stored = 1'b1;
              end else begin
                flags_d.overflow = 1'b1;
              end
            end
          end else if (bit_nx == u7e1_pkg::PARITY_BIT) begin
            parity_d = req_i.rx_level;
          end else begin
            // stop bit closes the frame
            flags_d.parity_error = (parity_q != ones_q[0]);
            flags_d.stop_error   = !req_i.rx_level;
            in_frame_d           = 1'b0;
            bit_idx_d            = '0;
          end
        end else begin
          ticks_d = ticks_q - u7e1_pkg::TICKS_W'(1);
        end
        line_prev_d = req_i.rx_level;
      end
    end

    flags_d.bytes_available = u7e1_pkg::AVAIL_W'(u7e1_pkg::ring_count(wr_idx_d, rd_idx_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= u7e1_pkg::PERIOD_RESET;
      line_prev_q <= 1'b1;
      in_frame_q  <= 1'b0;
      ticks_q     <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      ones_q      <= '0;
      parity_q    <= 1'b0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        period_q <= cfg_i.data;
      end
      line_prev_q <= line_prev_d;
      in_frame_q  <= in_frame_d;
      ticks_q     <= ticks_d;
      bit_idx_q   <= bit_idx_d;
      shift_q     <= shift_d;
      ones_q      <= ones_d;
      parity_q    <= parity_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags_d;
    end
  end

  u7e1_ring u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx_q),
    .wr_data_i (shift_d),
    .rd_en_i   (accept && is_read),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.read_valid      = flags_q.read_valid;
  assign rsp_o.read_byte       = flags_q.read_valid ? rd_data : '0;
  assign rsp_o.bytes_available = flags_q.bytes_available;
  assign rsp_o.byte_stored     = flags_q.byte_stored;
  assign rsp_o.overflow        = flags_q.overflow;
  assign rsp_o.parity_error    = flags_q.parity_error;
  assign rsp_o.stop_error      = flags_q.stop_error;

endmodule
